// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the glyph layout block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SJGL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SJGL_NEVER(lbl, cond, msg) \
  `SJGL_ASSERT(lbl, !(cond), msg)
`else
`define SJGL_ASSERT(lbl, prop, msg)
`define SJGL_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/sjgl_pkg.sv -----
// Types, constants and byte classification functions for the glyph layout.
// Used by every module of the block; depends on nothing.
package sjgl_pkg;

  localparam int GLYPH_WIDTH  = 6;
  localparam int GLYPH_HEIGHT = 12;
  localparam int SCREEN_WIDTH = 480;

  localparam int SPACE_GLYPH  = 176;
  localparam int ROW_GLYPHS   = 384;

  // Output queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_LF  = 8'h0A;

  typedef struct packed {
    logic       first;
    logic [8:0] start_x;
    logic [8:0] start_y;
    logic [7:0] cur;
    logic [7:0] nxt;
  } sjgl_item_t;

  typedef struct packed {
    logic [13:0] glyph;
    logic [8:0]  x;
    logic [15:0] y;
    logic        last;
  } sjgl_res_t;

  // Results pushed by one step: count 0..2, plus lead-held flag for checks
  typedef struct packed {
    logic [1:0] n;
    logic       lead_held;
  } sjgl_push_t;

  function automatic logic is_lead(input logic [7:0] c);
    return (c >= 8'h81 && c <= 8'h9F) || (c >= 8'hE0 && c <= 8'hEF);
  endfunction

  function automatic logic is_trail(input logic [7:0] c);
    return (c >= 8'h40 && c <= 8'h7E) || (c >= 8'h80 && c <= 8'hFC);
  endfunction

  function automatic logic [7:0] single_glyph(input logic [7:0] c);
    logic [7:0] g;
    g = 8'h00;
    if (c >= 8'h20 && c <= 8'h7E) begin
      g = c - 8'h20;
    end else if (c >= 8'hA1 && c <= 8'hDF) begin
      g = c - 8'h40;
    end else if (c >= 8'hF0 && c <= 8'hFD) begin
      g = c - 8'h50;
    end
    return g;
  endfunction

  // Lead table: bit 6 = slot populated, bits 5:0 = row entry
  function automatic logic [6:0] lead_entry(input logic [5:0] slot);
    logic [6:0] e;
    e = 7'd0;
    if (slot >= 6'd1 && slot <= 6'd4) begin
      e = {1'b1, slot - 6'd1};
    end else if (slot >= 6'd7 && slot <= 6'd42) begin
      e = {1'b1, slot - 6'd3};
    end else if (slot == 6'd45 || slot == 6'd46) begin
      e = {1'b1, slot - 6'd5};
    end
    return e;
  endfunction

  // First half-glyph of a double-byte character
  function automatic logic [13:0] double_glyph(input logic [7:0] lead,
                                               input logic [7:0] trail);
    logic [6:0]  e;
    logic [7:0]  t_off;
    logic [13:0] g;
    e     = lead_entry(lead[5:0]);
    t_off = trail - 8'h40;
    g     = 14'(SPACE_GLYPH);
    if (e[6] && is_trail(trail)) begin
      g = 14'(SPACE_GLYPH) + 14'(e[5:0]) * 14'(ROW_GLYPHS) + 14'({t_off, 1'b0});
    end
    return g;
  endfunction

endpackage

// ----- rtl/sjgl_layout.sv -----
// Cursor and pending-lead state plus the per-byte layout step.
// Depends on sjgl_pkg; feeds up to two results per step to the output queue.
module sjgl_layout import sjgl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  sjgl_item_t item,
  output sjgl_push_t push,
  output sjgl_res_t  res0,
  output sjgl_res_t  res1
);

  localparam logic [9:0] X_LIM1 = 10'(SCREEN_WIDTH - GLYPH_WIDTH);
  localparam logic [9:0] X_LIM2 = 10'(SCREEN_WIDTH - 2 * GLYPH_WIDTH);

  logic [7:0]  pend_r, pend_nxt;
  logic [9:0]  cx_r, cx_nxt;
  logic [15:0] cy_r, cy_nxt;
  logic [8:0]  lsx_r, lsx_nxt;
  logic        stop_r, stop_nxt;

  logic [7:0]  pend_e;
  logic [9:0]  cx_e;
  logic [15:0] cy_e;
  logic [8:0]  lsx_e;
  logic        stop_e;
  logic [9:0]  cx_p1;
  logic [13:0] g2;

  // Apply string start before handling the byte
  always_comb begin
    if (item.first) begin
      pend_e = 8'h00;
      cx_e   = {1'b0, item.start_x};
      cy_e   = {7'd0, item.start_y};
      lsx_e  = item.start_x;
      stop_e = 1'b0;
    end else begin
      pend_e = pend_r;
      cx_e   = cx_r;
      cy_e   = cy_r;
      lsx_e  = lsx_r;
      stop_e = stop_r;
    end
  end

  assign cx_p1 = cx_e + 10'(GLYPH_WIDTH);
  assign g2    = double_glyph(pend_e, item.cur);

  // Classify the byte and place its glyphs
  always_comb begin
    pend_nxt       = pend_e;
    cx_nxt         = cx_e;
    cy_nxt         = cy_e;
    lsx_nxt        = lsx_e;
    stop_nxt       = stop_e;
    push.n         = 2'd0;
    push.lead_held = (pend_e != 8'h00);
    res0.glyph     = 14'(single_glyph(item.cur));
    res0.x         = cx_e[8:0];
    res0.y         = cy_e;
    res0.last      = 1'b1;
    res1.glyph     = g2 + 14'd1;
    res1.x         = cx_p1[8:0];
    res1.y         = cy_e;
    res1.last      = 1'b1;
    priority if (stop_e) begin
      // drop everything until the next string
    end else if (item.cur == BYTE_NUL) begin
      stop_nxt = 1'b1;
    end else if (item.cur == BYTE_LF) begin
      cx_nxt   = {1'b0, lsx_e};
      cy_nxt   = cy_e + 16'(GLYPH_HEIGHT);
      pend_nxt = 8'h00;
    end else if (pend_e != 8'h00) begin
      if (cx_e > X_LIM2) begin
        stop_nxt = 1'b1;
      end else begin
        res0.glyph = g2;
        res0.last  = 1'b0;
        push.n     = 2'd2;
        cx_nxt     = cx_e + 10'(2 * GLYPH_WIDTH);
        pend_nxt   = 8'h00;
      end
    end else if (is_lead(item.cur) && is_trail(item.nxt)) begin
      pend_nxt = item.cur;
    end else if (cx_e > X_LIM1) begin
      stop_nxt = 1'b1;
    end else begin
      push.n = 2'd1;
      cx_nxt = cx_p1;
    end
  end

  // Advance state on each step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 8'h00;
      cx_r   <= 10'd0;
      cy_r   <= 16'd0;
      lsx_r  <= 9'd0;
      stop_r <= 1'b0;
    end else if (step_en) begin
      pend_r <= pend_nxt;
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      lsx_r  <= lsx_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

// ----- rtl/sjgl_out_fifo.sv -----
// Result queue: takes zero, one or two results per cycle, hands out one per cycle while out_tready is high.
// Depends on sjgl_pkg.
module sjgl_out_fifo import sjgl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_en,
  input  sjgl_push_t             push,
  input  sjgl_res_t              res0,
  input  sjgl_res_t              res1,
  output logic [CNT_W-1:0]       level,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  sjgl_res_t        mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wp_p1;
  logic [1:0]       n_in;
  logic             pop;
  sjgl_res_t        head;

  assign n_in  = wr_en ? push.n : 2'd0;
  assign pop   = out_tvalid && out_tready;
  assign wp_p1 = wp_r + PTR_W'(1);

  // Pointer and fill count bookkeeping
  always_comb begin
    wp_nxt  = wp_r + PTR_W'(n_in);
    rp_nxt  = pop ? rp_r + PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + CNT_W'(n_in) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store results in arrival order
  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem_r[wp_r] <= res0;
    end
    if (n_in == 2'd2) begin
      mem_r[wp_p1] <= res1;
    end
  end

  assign head       = mem_r[rp_r];
  assign level      = cnt_r;
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = OUT_TDATA_W'({head.y, head.x, head.glyph});
  assign out_tlast  = head.last;

endmodule

// ----- rtl/shift_jis_glyph_layout.sv -----
// Shift-JIS glyph layout: input register, single-pass layout step, result queue.
// Path: an accepted request waits in the input register until the queue has
// room for a pair, then its step pushes its results into the queue in order.
// Throughput: one input byte per cycle while the queue has room, one result
// out per cycle while out_tready is high; the input stalls while the 4-entry
// queue holds more than two results. Synchronous active-low reset clears the
// cursor, pending lead, stop flag and queue; no clearing pass.
`include "assert_macros.svh"
module shift_jis_glyph_layout import sjgl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata: start_x[8:0], start_y[17:9], cur_byte[25:18], next_byte[33:26]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: first_byte[0]
  input  logic [0:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata: glyph_index[13:0], pos_x[22:14], pos_y[38:23]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  logic             in_v_r, in_v_nxt;
  sjgl_item_t       item_r;
  logic             room;
  logic             step;
  logic             in_acc;
  logic [CNT_W-1:0] level;
  sjgl_push_t       push;
  sjgl_res_t        res0, res1;

  // Step only when the queue has room for a pair
  assign room      = (level <= CNT_W'(FIFO_DEPTH - 2));
  assign step      = in_v_r && room;
  assign in_tready = !in_v_r || room;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_acc) begin
      in_v_nxt = 1'b1;
    end else if (step) begin
      in_v_nxt = 1'b0;
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.first   <= in_tuser[0];
      item_r.start_x <= in_tdata[8:0];
      item_r.start_y <= in_tdata[17:9];
      item_r.cur     <= in_tdata[25:18];
      item_r.nxt     <= in_tdata[33:26];
    end
  end

  sjgl_layout u_layout (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .item    (item_r),
    .push    (push),
    .res0    (res0),
    .res1    (res1)
  );

  sjgl_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (step),
    .push       (push),
    .res0       (res0),
    .res1       (res1),
    .level      (level),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `SJGL_NEVER(a_fifo_level, level > CNT_W'(FIFO_DEPTH), "result queue overfilled")
  `SJGL_ASSERT(a_pair_whole, out_tvalid && out_tready && !out_tlast |=> out_tvalid, "pair split")
  `SJGL_ASSERT(a_pair_lead, step && push.n == 2'd2 |-> push.lead_held, "pair without lead")
  `SJGL_NEVER(a_push_code, step && push.n == 2'd3, "bad result count")

endmodule
